[hdl/rau_pkg.sv]
package rau_pkg;
	localparam int OperandWidth = 16;
	localparam int ResNumBits = 34;
	localparam int ResDenBits = 32;

	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_DIV = 3'd3;
	localparam logic [2:0] MODE_NEG = 3'd4;
	localparam logic [2:0] MODE_CMP = 3'd5;
	localparam logic [2:0] MODE_NRM = 3'd6;
	localparam logic [2:0] MODE_BAD = 3'd7;

	localparam logic [1:0] ORD_LT = 2'd0;
	localparam logic [1:0] ORD_EQ = 2'd1;
	localparam logic [1:0] ORD_GT = 2'd2;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_GCD  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_OUT  = 6'b010000,
		ST_PREP = 6'b100000
	} state_t;
endpackage

[hdl/rau_sermul.sv]
// Shift-add multiplier: one multiplier bit per cycle.
module rau_sermul import rau_pkg::*; #(
	parameter int W = OperandWidth + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	output logic             done,
	output logic [2*W-1:0]   p
);
	localparam int CW = $clog2(W + 1);
	logic [2*W-1:0] acc_q;
	logic [2*W-1:0] mc_q;
	logic [W-1:0]   mp_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= {{W{1'b0}}, a};
			mp_q  <= b;
		end else if (busy_q) begin
			if (mp_q[0])
				acc_q <= acc_q + mc_q;
			mc_q <= {mc_q[2*W-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[W-1:1]};
		end
	end

	assign done = busy_q && (cnt_q == CW'(1));
	assign p = mp_q[0] ? acc_q + mc_q : acc_q;
endmodule

[hdl/rau_gcd.sv]
// Binary gcd, one step per cycle; then bit-serial restoring division of
// numerator and denominator by the gcd.
module rau_gcd import rau_pkg::*; #(
	parameter int W = 2 * OperandWidth + 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] n_in,
	input  logic [W-1:0] d_in,
	output logic         done,
	output logic [W-1:0] n_out,
	output logic [W-1:0] d_out
);
	localparam int CW = $clog2(W + 1);
	typedef enum logic [3:0] {
		G_IDLE = 4'b0001, G_RUN = 4'b0010, G_DN = 4'b0100, G_DD = 4'b1000
	} gst_t;
	gst_t gst_q;
	logic [W-1:0]  x_q, y_q, g_q, n_q, d_q, quo_q, rem_q, dvd_q;
	logic [CW-1:0] k_q, cnt_q;
	logic [W:0]    trial;
	logic [W-1:0]  rsh;

	assign rsh = {rem_q[W-2:0], dvd_q[W-1]};
	assign trial = {1'b0, rsh} - {1'b0, g_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gst_q <= G_IDLE;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (gst_q)
				G_IDLE: if (start) gst_q <= G_RUN;
				G_RUN:  if (y_q == '0 || x_q == '0) gst_q <= G_DN;
				G_DN:   if (cnt_q == CW'(1)) gst_q <= G_DD;
				G_DD: if (cnt_q == CW'(1)) begin
					gst_q <= G_IDLE;
					done  <= 1'b1;
				end
				default: gst_q <= G_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (gst_q)
			G_IDLE: begin
				x_q <= n_in; y_q <= d_in; n_q <= n_in; d_q <= d_in; k_q <= '0;
			end
			G_RUN: begin
				if (y_q == '0 || x_q == '0) begin
					g_q   <= ((x_q | y_q) == '0) ? W'(1) : (x_q | y_q) << k_q;
					cnt_q <= CW'(W);
					dvd_q <= n_q; rem_q <= '0;
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1; y_q <= y_q >> 1; k_q <= k_q + 1'b1;
				end else if (!x_q[0]) x_q <= x_q >> 1;
				else if (!y_q[0]) y_q <= y_q >> 1;
				else if (x_q >= y_q) x_q <= (x_q - y_q) >> 1;
				else y_q <= (y_q - x_q) >> 1;
			end
			G_DN, G_DD: begin
				if (cnt_q == CW'(1) && gst_q == G_DN) begin
					quo_q <= {dvd_q[W-2:0], ~trial[W]};
					dvd_q <= d_q; rem_q <= '0; cnt_q <= CW'(W);
				end else begin
					dvd_q <= {dvd_q[W-2:0], ~trial[W]};
					rem_q <= trial[W] ? rsh : trial[W-1:0];
					cnt_q <= cnt_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign n_out = quo_q;
	assign d_out = dvd_q;
endmodule

[hdl/rational_arithmetic_unit_core.sv]
// Rational arithmetic unit. Each input transfer carries an opcode and two
// fractions a = a_num/a_den, b = b_num/b_den; exactly one result transfer
// follows. Add, subtract, multiply, divide, negate and normalize give the
// result reduced to lowest terms (sign in res_num, res_den positive);
// compare gives order (0 less, 1 equal, 2 greater) with 0/1 as fraction.
// A zero denominator, a zero divisor or opcode 7 sets error with all other
// fields zero. One item is in flight at a time: products come from one
// shift-add multiplier (one bit per cycle, run up to three times), then a
// binary gcd and two bit-serial divisions by the gcd; errors and compare
// skip the gcd, negate and normalize skip the multiplier. A new item is
// taken once the previous result has been transferred out of the output
// register.
module rational_arithmetic_unit_core import rau_pkg::*; #(
	parameter int OPERAND_WIDTH = OperandWidth
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// mode[2:0], a_num, a_den, b_num, b_den (low to high), zero padded
	input  logic [((3+4*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// res_num[33:0], res_den[65:34], order[67:66], error[68], zero padded
	output logic [71:0]                m_tdata
);
	localparam int OW = OPERAND_WIDTH;
	localparam int MW = OW + 1;
	localparam int GW = 2 * OW + 2;

	state_t state_q;
	logic [2:0]        mode_q;
	logic signed [MW-1:0] an_q, ad_q, bn_q, bd_q;
	logic [1:0]        step_q;
	logic signed [2*MW-1:0] p0_q, p1_q, p2_q;
	logic              mstart;
	logic              mdone;
	logic [MW-1:0]     ma, mb;
	logic [2*MW-1:0]   mp;
	logic              gstart, gdone;
	logic [GW-1:0]     gn, gd, gno, gdo;
	logic              neg_q;
	logic [ResNumBits-1:0] rn_q;
	logic [ResDenBits-1:0] rd_q;
	logic [1:0]        ord_q;
	logic              err_q;
	logic              mneg;
	logic [MW-1:0]     mam, mbm;
	logic signed [GW:0] sn;

	logic [2:0]  in_mode;
	logic signed [OW-1:0] in_an, in_ad, in_bn;
	logic [OW-1:0] in_bd;
	logic        in_err, uses_b;
	assign in_mode = s_tdata[2:0];
	assign in_an = s_tdata[3+OW-1:3];
	assign in_ad = s_tdata[3+2*OW-1:3+OW];
	assign in_bn = s_tdata[3+3*OW-1:3+2*OW];
	assign in_bd = s_tdata[3+4*OW-1:3+3*OW];
	assign uses_b = (in_mode <= MODE_DIV) || (in_mode == MODE_CMP);
	assign in_err = (in_mode == MODE_BAD) || (in_ad == '0) ||
		(uses_b && in_bd == '0) || (in_mode == MODE_DIV && in_bn == '0);

	assign s_tready = (state_q == ST_IDLE);

	// multiplier operands: magnitudes, sign tracked separately
	always_comb begin
		logic signed [MW-1:0] x, y;
		x = an_q; y = bd_q;
		unique case (step_q)
			2'd0: begin x = an_q; y = (mode_q == MODE_MUL) ? bn_q : bd_q; end
			2'd1: begin x = ad_q; y = bn_q; end
			default: begin x = ad_q; y = bd_q; end
		endcase
		mneg = x[MW-1] ^ y[MW-1];
		mam = x[MW-1] ? MW'(-x) : MW'(x);
		mbm = y[MW-1] ? MW'(-y) : MW'(y);
	end
	assign ma = mam;
	assign mb = mbm;

	rau_sermul #(.W(MW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart), .a(ma), .b(mb),
		.done(mdone), .p(mp)
	);

	// signed numerator and positive denominator before reduction
	always_comb begin
		logic signed [GW:0] n, d;
		unique case (mode_q)
			MODE_ADD: n = GW'(p0_q) + GW'(p1_q);
			MODE_SUB: n = GW'(p0_q) - GW'(p1_q);
			MODE_NEG: n = -(GW+1)'(an_q);
			MODE_NRM: n = (GW+1)'(an_q);
			default:  n = (GW+1)'(p0_q);
		endcase
		d = (mode_q == MODE_NEG || mode_q == MODE_NRM) ? (GW+1)'(ad_q) :
			(mode_q == MODE_DIV) ? (GW+1)'(p1_q) : (GW+1)'(p2_q);
		if (mode_q == MODE_DIV && d < 0) n = -n;
		sn = n;
		gd = d[GW] ? GW'(-d) : GW'(d);
	end
	assign gn = sn[GW] ? GW'(-sn) : GW'(sn);

	rau_gcd #(.W(GW)) u_gcd (
		.clk(clk), .arst_n(arst_n), .start(gstart), .n_in(gn), .d_in(gd),
		.done(gdone), .n_out(gno), .d_out(gdo)
	);

	assign mstart = (state_q == ST_PREP);

	logic gcd_go_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
			step_q   <= '0;
			gcd_go_q <= 1'b0;
		end else begin
			gcd_go_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_tvalid) begin
					step_q <= '0;
					if (in_err) begin
						state_q <= ST_OUT; m_tvalid <= 1'b1;
					end else if (in_mode == MODE_NEG || in_mode == MODE_NRM) begin
						state_q <= ST_GCD; gcd_go_q <= 1'b1;
					end else state_q <= ST_PREP;
				end
				ST_PREP: state_q <= ST_MUL;
				ST_MUL: if (mdone) begin
					if (step_q == 2'd2 || (mode_q == MODE_DIV && step_q == 2'd1) ||
						(mode_q == MODE_CMP && step_q == 2'd1)) begin
						if (mode_q == MODE_CMP) begin
							state_q <= ST_OUT; m_tvalid <= 1'b1;
						end else begin
							state_q <= ST_GCD; gcd_go_q <= 1'b1;
						end
					end else begin
						step_q <= (mode_q == MODE_MUL) ? 2'd2 : step_q + 1'b1;
						state_q <= ST_PREP;
					end
				end
				ST_GCD: if (gdone) begin
					state_q <= ST_OUT; m_tvalid <= 1'b1;
				end
				ST_OUT: if (m_tready) begin
					state_q <= ST_IDLE; m_tvalid <= 1'b0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic [GW-1:0] gnum;
	assign gnum = neg_q ? GW'(-gno) : gno;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			mode_q <= in_mode;
			err_q  <= in_err;
			an_q <= in_ad[OW-1] ? -MW'(in_an) : MW'(in_an);
			ad_q <= in_ad[OW-1] ? -MW'(in_ad) : MW'(in_ad);
			bn_q <= MW'(in_bn);
			bd_q <= MW'({1'b0, in_bd});
			ord_q <= ORD_LT;
			rn_q <= '0;
			rd_q <= in_err ? '0 : ResDenBits'(1);
		end
		if (mdone) begin
			case (step_q)
				2'd0: p0_q <= mneg ? -(2*MW)'(mp) : (2*MW)'(mp);
				2'd1: p1_q <= mneg ? -(2*MW)'(mp) : (2*MW)'(mp);
				default: p2_q <= mneg ? -(2*MW)'(mp) : (2*MW)'(mp);
			endcase
			if (mode_q == MODE_CMP && step_q == 2'd1) begin
				logic signed [2*MW-1:0] r;
				r = mneg ? -(2*MW)'(mp) : (2*MW)'(mp);
				ord_q <= (p0_q < r) ? ORD_LT : (p0_q == r) ? ORD_EQ : ORD_GT;
			end
		end
		if (gcd_go_q) neg_q <= sn[GW];
		if (gdone) begin
			rn_q <= ResNumBits'(gnum);
			rd_q <= ResDenBits'(gdo);
		end
	end

	// gcd start is registered, so the gcd launches in the cycle after the operands settle
	logic gstart_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gstart_q <= 1'b0;
		else gstart_q <= gcd_go_q;
	end
	assign gstart = gstart_q;

	assign m_tdata = {3'b000, err_q, ord_q, rd_q, rn_q};
endmodule

[hdl/rau_checker.sv]
module rau_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [71:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("overlap");
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[68] |-> m_tdata[67:0] == '0) else $error("err");
	a_ord: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[67:66] != 2'd3) else $error("order");
endmodule

bind rational_arithmetic_unit_core rau_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
